// ----- rtl/core/bcdasc_pkg.sv -----
// bcdasc_pkg: constants, types and digit step functions for the bcd add/sub/compare core
// no dependencies; used by bcdasc_slice, bcdasc_out and bcd_add_sub_compare_core
`default_nettype none

package bcdasc_pkg;

   // number geometry
   localparam int DIGITS       = 16;
   localparam int STAGES       = 4;
   localparam int SLICE_DIGITS = (DIGITS + STAGES - 1) / STAGES;
   localparam int SLICE_BITS   = 4 * SLICE_DIGITS;
   localparam int PAD_BITS     = STAGES * SLICE_BITS;
   localparam int USED_BITS    = 4 * DIGITS;
   localparam int DATA_BITS    = 64;

   // operation codes; the unused code behaves as compare
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_CMP = 2'd2
   } op_type;

   // ordering codes, two bit signed
   localparam logic [1:0] ORDER_EQ = 2'b00;
   localparam logic [1:0] ORDER_GT = 2'b01;
   localparam logic [1:0] ORDER_LT = 2'b11;

   typedef logic [3:0] digit_type;

   // data carried from one pipeline stage to the next
   typedef struct packed {
      logic                valid;
      logic [1:0]          op;
      logic [PAD_BITS-1:0] a_rem;
      logic [PAD_BITS-1:0] b_rem;
      logic [PAD_BITS-1:0] sum;
      logic [PAD_BITS-1:0] diff;
      logic [1:0]          carry;
      logic [1:0]          borrow;
      logic [1:0]          order;
      logic                bad;
   } stage_type;

   // one decimal add step: returns {carry out, digit}, digit sum at most 33
   function automatic logic [5:0] add_step(digit_type a, digit_type b, logic [1:0] cin);
      logic [5:0] s;
      logic [5:0] r;
      logic [1:0] c;
      s = {2'b00, a} + {2'b00, b} + {4'b0000, cin};
      if (s >= 6'd30) begin
         r = s - 6'd30;
         c = 2'd3;
      end else if (s >= 6'd20) begin
         r = s - 6'd20;
         c = 2'd2;
      end else if (s >= 6'd10) begin
         r = s - 6'd10;
         c = 2'd1;
      end else begin
         r = s;
         c = 2'd0;
      end
      return {c, r[3:0]};
   endfunction

   // one decimal subtract step: t = a + 20 - b - borrow lies in 3..35
   function automatic logic [5:0] sub_step(digit_type a, digit_type b, logic [1:0] bin);
      logic [5:0] t;
      logic [5:0] r;
      logic [1:0] c;
      t = 6'd20 + {2'b00, a} - {2'b00, b} - {4'b0000, bin};
      if (t >= 6'd30) begin
         r = t - 6'd30;
         c = 2'd0;
      end else if (t >= 6'd20) begin
         r = t - 6'd20;
         c = 2'd0;
      end else if (t >= 6'd10) begin
         r = t - 6'd10;
         c = 2'd1;
      end else begin
         r = t;
         c = 2'd2;
      end
      return {c, r[3:0]};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bcdasc_slice.sv -----
// bcdasc_slice: one pipeline stage, works on the lowest slice of remaining digits
// depends on bcdasc_pkg (stage_type, add_step, sub_step, constants)
`default_nettype none

module bcdasc_slice (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bcdasc_pkg::stage_type d,
   output bcdasc_pkg::stage_type      q
);

   bcdasc_pkg::stage_type data_in;
   bcdasc_pkg::stage_type data_ff;
   logic                  valid_ff;

   // add and subtract chains plus compare over this slice's digits
   always_comb begin
      logic [1:0]                       carry;
      logic [1:0]                       borrow;
      logic [1:0]                       ord;
      logic                             bad;
      logic [5:0]                       add_r;
      logic [5:0]                       sub_r;
      logic [bcdasc_pkg::SLICE_BITS-1:0] sum_slice;
      logic [bcdasc_pkg::SLICE_BITS-1:0] diff_slice;
      bcdasc_pkg::digit_type            da;
      bcdasc_pkg::digit_type            db;
      carry      = d.carry;
      borrow     = d.borrow;
      ord        = d.order;
      bad        = d.bad;
      sum_slice  = '0;
      diff_slice = '0;
      for (int j = 0; j < bcdasc_pkg::SLICE_DIGITS; j++) begin
         da = d.a_rem[4*j +: 4];
         db = d.b_rem[4*j +: 4];
         add_r = bcdasc_pkg::add_step(da, db, carry);
         sub_r = bcdasc_pkg::sub_step(da, db, borrow);
         sum_slice[4*j +: 4]  = add_r[3:0];
         diff_slice[4*j +: 4] = sub_r[3:0];
         carry  = add_r[5:4];
         borrow = sub_r[5:4];
         // a higher digit that differs overrides the lower ones
         if (da > db) begin
            ord = bcdasc_pkg::ORDER_GT;
         end else if (da < db) begin
            ord = bcdasc_pkg::ORDER_LT;
         end
         if ((da > 4'd9) || (db > 4'd9)) begin
            bad = 1'b1;
         end
      end
      data_in        = d;
      data_in.a_rem  = d.a_rem >> bcdasc_pkg::SLICE_BITS;
      data_in.b_rem  = d.b_rem >> bcdasc_pkg::SLICE_BITS;
      data_in.sum    = {sum_slice, d.sum[bcdasc_pkg::PAD_BITS-1:bcdasc_pkg::SLICE_BITS]};
      data_in.diff   = {diff_slice, d.diff[bcdasc_pkg::PAD_BITS-1:bcdasc_pkg::SLICE_BITS]};
      data_in.carry  = carry;
      data_in.borrow = borrow;
      data_in.order  = ord;
      data_in.bad    = bad;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= d.valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      q       = data_ff;
      q.valid = valid_ff;
   end

`ifndef SYNTHESIS
   a_valid_follows : assert property (@(posedge clock) disable iff (reset)
      d.valid |=> q.valid)
      else $error("slice dropped a transfer");
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !d.valid |=> !q.valid)
      else $error("slice invented a transfer");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bcdasc_out.sv -----
// bcdasc_out: selects sum, difference or zero by operation and registers the result
// depends on bcdasc_pkg (stage_type, op_type, order codes, widths)
`default_nettype none

module bcdasc_out (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bcdasc_pkg::stage_type                d,
   output logic                                      rsp_strobe,
   output logic        [bcdasc_pkg::DATA_BITS-1:0]   rsp_result,
   output logic signed [1:0]                         rsp_order,
   output logic                                      rsp_bad_digit
);

   logic                             strobe_ff;
   logic [bcdasc_pkg::DATA_BITS-1:0] result_in;
   logic [bcdasc_pkg::DATA_BITS-1:0] result_ff;
   logic [1:0]                       order_ff;
   logic                             bad_ff;

   // operation select; subtract saturates at zero when a is less than b
   always_comb begin
      case (d.op)
         bcdasc_pkg::OP_ADD: begin
            result_in = bcdasc_pkg::DATA_BITS'(d.sum[bcdasc_pkg::USED_BITS-1:0]);
         end
         bcdasc_pkg::OP_SUB: begin
            if (d.order == bcdasc_pkg::ORDER_LT) begin
               result_in = '0;
            end else begin
               result_in = bcdasc_pkg::DATA_BITS'(d.diff[bcdasc_pkg::USED_BITS-1:0]);
            end
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= d.valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      result_ff <= result_in;
      order_ff  <= d.order;
      bad_ff    <= d.bad;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_result    = result_ff;
   assign rsp_order     = order_ff;
   assign rsp_bad_digit = bad_ff;

`ifndef SYNTHESIS
   a_equal_sub_zero : assert property (@(posedge clock) disable iff (reset)
      (d.valid && (d.op == bcdasc_pkg::OP_SUB) && (d.order == bcdasc_pkg::ORDER_EQ)
       && !d.bad) |=> (rsp_result == '0))
      else $error("subtract of equal valid operands is not zero");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bcd_add_sub_compare_core.sv -----
// bcd_add_sub_compare_core: top level of the packed bcd adder, subtractor and comparator
// depends on bcdasc_pkg, bcdasc_slice and bcdasc_out
`default_nettype none

// Takes one operation (add, saturating subtract, compare) on two packed-BCD numbers every
// clock cycle: a transfer happens when start is high and busy is low, and busy is high only
// during reset and in the first cycle after it. Each transfer gives exactly one result,
// marked by rsp_strobe for one cycle, once through the slice registers and the output
// register; results arrive in request order and cannot be held off. The digit carry,
// borrow and compare chains run through four register stages of four digits each, then an
// output register selects and saturates the result. rsp_order is +1, 0 or -1 for a above,
// equal to or below b; rsp_bad_digit flags any input digit above 9.

module bcd_add_sub_compare_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic        [1:0]                    req_operation,
   input  wire logic        [bcdasc_pkg::DATA_BITS-1:0] req_operand_a,
   input  wire logic        [bcdasc_pkg::DATA_BITS-1:0] req_operand_b,
   output logic                                      rsp_strobe,
   output logic             [bcdasc_pkg::DATA_BITS-1:0] rsp_result,
   output logic signed      [1:0]                    rsp_order,
   output logic                                      rsp_bad_digit
);

   logic                  busy_ff;
   bcdasc_pkg::stage_type entry;
   bcdasc_pkg::stage_type chain [bcdasc_pkg::STAGES+1];

   // busy during reset and straight after it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // request enters the pipeline with unused digits cleared
   always_comb begin
      entry.valid  = start && !busy_ff;
      entry.op     = req_operation;
      entry.a_rem  = bcdasc_pkg::PAD_BITS'(req_operand_a[bcdasc_pkg::USED_BITS-1:0]);
      entry.b_rem  = bcdasc_pkg::PAD_BITS'(req_operand_b[bcdasc_pkg::USED_BITS-1:0]);
      entry.sum    = '0;
      entry.diff   = '0;
      entry.carry  = 2'd0;
      entry.borrow = 2'd0;
      entry.order  = bcdasc_pkg::ORDER_EQ;
      entry.bad    = 1'b0;
   end

   assign chain[0] = entry;

   // digit slice stages, lowest digits first
   for (genvar s = 0; s < bcdasc_pkg::STAGES; s++) begin : g_slice
      bcdasc_slice u_slice (
         .clock (clock),
         .reset (reset),
         .d     (chain[s]),
         .q     (chain[s+1])
      );
   end

   // result select and output register
   bcdasc_out u_out (
      .clock         (clock),
      .reset         (reset),
      .d             (chain[bcdasc_pkg::STAGES]),
      .rsp_strobe    (rsp_strobe),
      .rsp_result    (rsp_result),
      .rsp_order     (rsp_order),
      .rsp_bad_digit (rsp_bad_digit)
   );

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("accepted transfer gave no result after five cycles");
   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 5))
      else $error("result strobe without a matching request");
   a_order_code : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_order != 2'sb10))
      else $error("ordering output out of range");
`endif

endmodule

`default_nettype wire
